### src/ctsw_pkg.sv
// ctsw_pkg: shared types and codes for the clipped trapezoid span walker
// no dependencies; used by src/clipped_trapezoid_span_walker.sv
package ctsw_pkg;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    REG_CLIP_LEFT   = 2'd0,
    REG_CLIP_TOP    = 2'd1,
    REG_CLIP_RIGHT  = 2'd2,
    REG_CLIP_BOTTOM = 2'd3
  } reg_index_e;

  localparam int unsigned FixW = 32;
  localparam int unsigned CoordW = 16;

  localparam logic [CoordW-1:0] ClipLeftRst   = 16'h0000;
  localparam logic [CoordW-1:0] ClipTopRst    = 16'h0000;
  localparam logic [CoordW-1:0] ClipRightRst  = 16'h7fff;
  localparam logic [CoordW-1:0] ClipBottomRst = 16'h7fff;

  // one result item
  typedef struct packed {
    logic              span_visible;
    logic [CoordW-1:0] span_x;
    logic [CoordW-1:0] span_row;
    logic [CoordW-1:0] span_width;
    logic              last_row;
    logic [FixW-1:0]   edge_a_now;
    logic [FixW-1:0]   edge_b_now;
    logic [CoordW-1:0] row_now;
  } span_t;

  // round signed 16.16 to nearest column, halves up, kept 17 bits wide
  function automatic logic [CoordW:0] round_col(input logic [FixW-1:0] v);
    logic [FixW:0] biased;
    biased = {v[FixW-1], v} + 33'h0_0000_8000;
    return biased[FixW:CoordW];
  endfunction

endpackage

### src/clipped_trapezoid_span_walker.sv
// clipped_trapezoid_span_walker: top level, edge walk, clip and result register
// depends on ctsw_pkg
//
// Walks a flat trapezoid one scanline per step item and clips each scanline
// to the configured rectangle (left/top inclusive, right/bottom exclusive).
// A load item stores edges, slopes, first row and row count and gives no
// result; a step item with rows left gives exactly one result, one with no
// rows left gives none. Items are taken at one per clock cycle: edges and row
// advance in the accept cycle and the span result goes into a single output
// register on acceptance, so throughput is set only by that register draining
// (in_ready_o is high whenever it is empty or being read). The user must write
// clip registers via the plain write port only while idle; block doesn't check.
module clipped_trapezoid_span_walker (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // input items
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        opcode_i,
  input  logic [31:0] edge_a_start_i,
  input  logic [31:0] edge_b_start_i,
  input  logic [31:0] edge_a_step_i,
  input  logic [31:0] edge_b_step_i,
  input  logic [15:0] first_row_i,
  input  logic [15:0] row_total_i,
  // result items
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        span_visible_o,
  output logic [15:0] span_x_o,
  output logic [15:0] span_row_o,
  output logic [15:0] span_width_o,
  output logic        last_row_o,
  output logic [31:0] edge_a_now_o,
  output logic [31:0] edge_b_now_o,
  output logic [15:0] row_now_o
);

  logic [15:0] clip_left_q, clip_top_q, clip_right_q, clip_bottom_q;
  logic [31:0] edge_a_acc_q, edge_b_acc_q, edge_a_inc_q, edge_b_inc_q;
  logic [31:0] edge_a_acc_d, edge_b_acc_d;
  logic [15:0] row_q, row_d, rows_left_q, rows_left_d;

  logic        out_valid_q;
  ctsw_pkg::span_t res_q, res_d;

  logic in_acc, is_step, emit;
  logic row_in;
  logic [16:0] col_a, col_b, c_lo, c_hi, c1, c2, wid;
  logic [16:0] left_x, right_x;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;
  assign is_step    = (ctsw_pkg::opcode_e'(opcode_i) == ctsw_pkg::OP_STEP);
  assign emit       = in_acc && is_step && (rows_left_q != 16'd0);

  // span of the current scanline
  always_comb begin
    col_a   = ctsw_pkg::round_col(edge_a_acc_q);
    col_b   = ctsw_pkg::round_col(edge_b_acc_q);
    left_x  = {clip_left_q[15], clip_left_q};
    right_x = {clip_right_q[15], clip_right_q};
    row_in  = ($signed(row_q) >= $signed(clip_top_q)) &&
              ($signed(row_q) < $signed(clip_bottom_q));
    if ($signed(col_b) < $signed(col_a)) begin
      c_lo = col_b;
      c_hi = col_a;
    end else begin
      c_lo = col_a;
      c_hi = col_b;
    end
    c1  = ($signed(c_lo) < $signed(left_x)) ? left_x : c_lo;
    c2  = ($signed(c_hi) > $signed(right_x)) ? right_x : c_hi;
    wid = c2 - c1;

    edge_a_acc_d = edge_a_acc_q + edge_a_inc_q;
    edge_b_acc_d = edge_b_acc_q + edge_b_inc_q;
    row_d        = row_q + 16'd1;
    rows_left_d  = rows_left_q - 16'd1;

    res_d.span_visible = row_in && ($signed(c1) < $signed(c2));
    res_d.span_x       = res_d.span_visible ? c1[15:0] : 16'd0;
    res_d.span_width   = res_d.span_visible ? wid[15:0] : 16'd0;
    res_d.span_row     = row_q;
    res_d.last_row     = (rows_left_d == 16'd0);
    res_d.edge_a_now   = edge_a_acc_d;
    res_d.edge_b_now   = edge_b_acc_d;
    res_d.row_now      = row_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_left_q   <= ctsw_pkg::ClipLeftRst;
      clip_top_q    <= ctsw_pkg::ClipTopRst;
      clip_right_q  <= ctsw_pkg::ClipRightRst;
      clip_bottom_q <= ctsw_pkg::ClipBottomRst;
    end else if (cfg_we_i) begin
      unique case (ctsw_pkg::reg_index_e'(cfg_index_i))
        ctsw_pkg::REG_CLIP_LEFT:   clip_left_q   <= cfg_data_i;
        ctsw_pkg::REG_CLIP_TOP:    clip_top_q    <= cfg_data_i;
        ctsw_pkg::REG_CLIP_RIGHT:  clip_right_q  <= cfg_data_i;
        ctsw_pkg::REG_CLIP_BOTTOM: clip_bottom_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // walker state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_a_acc_q <= '0;
      edge_b_acc_q <= '0;
      edge_a_inc_q <= '0;
      edge_b_inc_q <= '0;
      row_q        <= '0;
      rows_left_q  <= '0;
    end else if (in_acc && !is_step) begin
      edge_a_acc_q <= edge_a_start_i;
      edge_b_acc_q <= edge_b_start_i;
      edge_a_inc_q <= edge_a_step_i;
      edge_b_inc_q <= edge_b_step_i;
      row_q        <= first_row_i;
      rows_left_q  <= row_total_i;
    end else if (emit) begin
      edge_a_acc_q <= edge_a_acc_d;
      edge_b_acc_q <= edge_b_acc_d;
      row_q        <= row_d;
      rows_left_q  <= rows_left_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign span_visible_o = res_q.span_visible;
  assign span_x_o       = res_q.span_x;
  assign span_row_o     = res_q.span_row;
  assign span_width_o   = res_q.span_width;
  assign last_row_o     = res_q.last_row;
  assign edge_a_now_o   = res_q.edge_a_now;
  assign edge_b_now_o   = res_q.edge_b_now;
  assign row_now_o      = res_q.row_now;

  // a step with rows left always produces an item next cycle
  a_emit_gives_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> out_valid_q)
    else $error("step with rows left produced no item");

  // row count drops by one per emitted span
  a_rows_count_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> (rows_left_q == $past(rows_left_q) - 16'd1))
    else $error("row count not decremented");

  // an invisible span carries zero column and width
  a_invisible_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_q.span_visible) |->
      (res_q.span_x == 16'd0 && res_q.span_width == 16'd0))
    else $error("invisible span with nonzero column or width");

  // a visible span always has width
  a_visible_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.span_visible) |-> (res_q.span_width != 16'd0))
    else $error("visible span of zero width");

endmodule
